FILE: hw/rtl/bca_pkg.sv
// Shared types, constants and fixed-point helpers for the barometer compensation block.
package bca_pkg;

	localparam int FRAC_BITS_DEF = 23;

	// Intermediate word: holds +-2^61 after saturation
	localparam int IW = 63;
	typedef logic signed [IW-1:0] word_t;

	localparam word_t LIM = {2'b01, 61'd0};

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALIB_LOW  = 3'd0,
		REG_CALIB_MID  = 3'd1,
		REG_CALIB_HIGH = 3'd2,
		REG_P_OSR      = 3'd3,
		REG_T_OSR      = 3'd4,
		REG_ALT_OFFSET = 3'd5
	} reg_idx_t;

	localparam logic [2:0] P_OSR_RST = 3'd4;
	localparam logic [2:0] T_OSR_RST = 3'd3;
	localparam logic signed [20:0] ALT_OFFSET_RST = 21'sd16300;

	// Half of each oversampling scale factor, for rounding
	localparam logic [21:0] KHALF [8] = '{
		22'd262144, 22'd786432, 22'd1835008, 22'd3932160,
		22'd126976, 22'd258048, 22'd520192, 22'd1044480
	};
	// Scale factor = (2^m - 1) * 2^e; e is 19 for the low four codes, 13 above
	localparam int SCALE_EXP_LO = 19;
	localparam int SCALE_EXP_HI = 13;

	// floor(x / 125) = (x * DIV125_RECIP) >> DIV125_SH for x below 2^60
	localparam logic [63:0] DIV125_RECIP = 64'd1180591620717411304;
	localparam int DIV125_SH = 67;
	localparam int DIV1000_HALF = 500;

	localparam int SEA_LEVEL_PA = 101400;
	localparam logic signed [30:0] K082_Q30 = 31'sd880468296;
	localparam int K082_SH = 30;

	function automatic word_t sat_add(word_t a, word_t b);
		logic signed [IW:0] s;
		s = (IW+1)'(a) + (IW+1)'(b);
		if (s > (IW+1)'(LIM))
			return LIM;
		else if (s < -((IW+1)'(LIM)))
			return -LIM;
		else
			return word_t'(s);
	endfunction

	// Shift right by s, rounding to nearest with ties away from zero
	function automatic word_t rnd_shift(word_t x, int s);
		word_t bias;
		bias = word_t'(64'd1 << (s - 1)) - word_t'(x[IW-1]);
		return (x + bias) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(word_t x);
		if (x > word_t'(64'sd2147483647))
			return 32'sh7FFFFFFF;
		else if (x < word_t'(-64'sd2147483648))
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [23:0] sat24(word_t x);
		if (x > word_t'(64'sd8388607))
			return 24'sh7FFFFF;
		else if (x < word_t'(-64'sd8388608))
			return 24'sh800000;
		else
			return x[23:0];
	endfunction

endpackage

FILE: hw/rtl/bca_dly.sv
// Enabled shift-register delay line for pipeline payload.
module bca_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++)
				tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

FILE: hw/rtl/bca_mul.sv
// Two-stage signed multiplier: four registered partial products, then a registered sum.
module bca_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] prod
);

	localparam int LA = WA / 2;
	localparam int LB = WB / 2;
	localparam int HA = WA - LA;
	localparam int HB = WB - LB;
	localparam int WP = WA + WB;

	logic signed [HA-1:0] ah;
	logic signed [HB-1:0] bh;
	logic [LA-1:0] al;
	logic [LB-1:0] bl;

	logic signed [HA+HB-1:0] hh;
	logic signed [HA+LB:0]   hl;
	logic signed [LA+HB:0]   lh;
	logic [LA+LB-1:0]        ll;

	logic signed [HA+HB-1:0] hh_s1;
	logic signed [HA+LB:0]   hl_s1;
	logic signed [LA+HB:0]   lh_s1;
	logic [LA+LB-1:0]        ll_s1;
	logic signed [WP-1:0]    sum;
	logic signed [WP-1:0]    prod_s2;

	assign ah = a[WA-1:LA];
	assign al = a[LA-1:0];
	assign bh = b[WB-1:LB];
	assign bl = b[LB-1:0];

	assign hh = ah * bh;
	assign hl = ah * $signed({1'b0, bl});
	assign lh = $signed({1'b0, al}) * bh;
	assign ll = al * bl;

	assign sum = (WP'(hh_s1) <<< (LA + LB)) + (WP'(hl_s1) <<< LA)
		+ (WP'(lh_s1) <<< LB) + $signed(WP'(ll_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1   <= hh;
			hl_s1   <= hl;
			lh_s1   <= lh;
			ll_s1   <= ll;
			prod_s2 <= sum;
		end
	end

	assign prod = prod_s2;

endmodule

FILE: hw/rtl/bca_mulsh.sv
// Three-stage multiply, round-shift (ties away from zero) and saturate to the word limit.
module bca_mulsh #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int SH = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output bca_pkg::word_t       y
);

	localparam int WP = WA + WB;
	localparam int CW = (WP + 1 > bca_pkg::IW + 1) ? WP + 1 : bca_pkg::IW + 1;
	localparam logic signed [CW-1:0] LIM_E = CW'(bca_pkg::LIM);

	logic signed [WP-1:0] prod;
	logic signed [CW-1:0] pe;
	logic signed [CW-1:0] bias;
	logic signed [CW-1:0] r;
	bca_pkg::word_t       y_s3;

	bca_mul #(.WA(WA), .WB(WB)) u_mul (
		.clk  (clk),
		.en   (en),
		.a    (a),
		.b    (b),
		.prod (prod)
	);

	assign pe   = CW'(prod);
	assign bias = $signed(CW'(1) << (SH - 1)) - $signed({{(CW-1){1'b0}}, prod[WP-1]});
	assign r    = (pe + bias) >>> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > LIM_E)
				y_s3 <= bca_pkg::LIM;
			else if (r < -LIM_E)
				y_s3 <= -bca_pkg::LIM;
			else
				y_s3 <= r[bca_pkg::IW-1:0];
		end
	end

	assign y = y_s3;

endmodule

FILE: hw/rtl/bca_scale.sv
// Four-stage raw sample scaling: divide by the oversampling factor with rounding, saturate.
module bca_scale #(
	parameter int FRAC_BITS = bca_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [23:0]        raw,
	input  logic [2:0]                code,
	output logic signed [FRAC_BITS+5:0] sc
);

	localparam int SW  = FRAC_BITS + 6;
	localparam int NW  = FRAC_BITS + 25;
	localparam int WX  = FRAC_BITS + 12;
	localparam int SHQ = WX + 8;
	localparam int RW  = SHQ + 1;

	// ceil(2^SHQ / (2^m - 1)) per code
	localparam logic [63:0] RECIP [8] = '{
		(64'd1 << SHQ),
		((64'd1 << SHQ) + 64'd2) / 64'd3,
		((64'd1 << SHQ) + 64'd6) / 64'd7,
		((64'd1 << SHQ) + 64'd14) / 64'd15,
		((64'd1 << SHQ) + 64'd30) / 64'd31,
		((64'd1 << SHQ) + 64'd62) / 64'd63,
		((64'd1 << SHQ) + 64'd126) / 64'd127,
		((64'd1 << SHQ) + 64'd254) / 64'd255
	};
	localparam logic [WX-1:0] TOPX = WX'(1) << (FRAC_BITS + 5);

	logic [23:0]          mag;
	logic [NW-1:0]        num;
	logic [NW-1:0]        nsh;
	logic [WX-1:0]        x_s1;
	logic [RW-1:0]        r_s1;
	logic                 neg_s1;
	logic                 neg_d3;
	logic signed [WX+RW+1:0] prod;
	logic [WX-1:0]        q;
	logic [WX-1:0]        qs;
	logic signed [SW-1:0] sc_s4;

	assign mag = raw[23] ? 24'(-raw) : 24'(raw);
	assign num = (NW'(mag) << FRAC_BITS) + NW'(bca_pkg::KHALF[code]);
	assign nsh = code[2] ? (num >> bca_pkg::SCALE_EXP_HI) : (num >> bca_pkg::SCALE_EXP_LO);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= nsh[WX-1:0];
			r_s1   <= RECIP[code][RW-1:0];
			neg_s1 <= raw[23];
		end
	end

	bca_mul #(.WA(WX + 1), .WB(RW + 1)) u_mul (
		.clk  (clk),
		.en   (en),
		.a    ($signed({1'b0, x_s1})),
		.b    ($signed({1'b0, r_s1})),
		.prod (prod)
	);

	bca_dly #(.W(1), .N(2)) u_neg_dly (
		.clk (clk),
		.en  (en),
		.d   (neg_s1),
		.q   (neg_d3)
	);

	assign q = prod[SHQ+WX-1:SHQ];

	// Negative side may reach -2^(F+5); positive side stops one below
	always_comb begin
		if (neg_d3)
			qs = (q > TOPX) ? TOPX : q;
		else
			qs = (q > TOPX - WX'(1)) ? TOPX - WX'(1) : q;
	end

	always_ff @(posedge clk) begin
		if (en)
			sc_s4 <= neg_d3 ? -$signed(qs[SW-1:0]) : $signed(qs[SW-1:0]);
	end

	assign sc = sc_s4;

endmodule

FILE: hw/rtl/barometer_compensation_altitude.sv
// Top level: config registers, 32-stage compensation and altitude pipeline.
//
// channel | signals                                  | direction
// in      | in_valid, in_ready, raw_pressure,        | into block
//         | raw_temperature                          |
// out     | out_valid, out_ready, temperature_q8,    | out of block
//         | pressure_q4, altitude_cm                 |
// cfg     | cfg_wr, cfg_index, cfg_data              | into block, write only
//
// One transaction enters per cycle unless the output stalls; the pipeline depth is
// set by the longest dependent path: sample scaling, the nested pressure polynomial,
// the divide by 1000 and the three dependent multiplies of the altitude cubic.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
module barometer_compensation_altitude #(
	parameter int FRAC_BITS = bca_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [23:0]                raw_pressure,
	input  logic signed [23:0]                raw_temperature,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [23:0]                temperature_q8,
	output logic signed [31:0]                pressure_q4,
	output logic signed [31:0]                altitude_cm,
	input  logic                              cfg_wr,
	input  logic [bca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bca_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int LAT = 32;
	localparam int SW  = FRAC_BITS + 6;
	localparam int IW  = bca_pkg::IW;

	// configuration
	logic [63:0]        calib_lo_q;
	logic [63:0]        calib_mid_q;
	logic [15:0]        calib_hi_q;
	logic [2:0]         p_osr_q;
	logic [2:0]         t_osr_q;
	logic signed [20:0] alt_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_lo_q  <= '0;
			calib_mid_q <= '0;
			calib_hi_q  <= '0;
			p_osr_q     <= bca_pkg::P_OSR_RST;
			t_osr_q     <= bca_pkg::T_OSR_RST;
			alt_off_q   <= bca_pkg::ALT_OFFSET_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				bca_pkg::REG_CALIB_LOW:  calib_lo_q  <= cfg_data;
				bca_pkg::REG_CALIB_MID:  calib_mid_q <= cfg_data;
				bca_pkg::REG_CALIB_HIGH: calib_hi_q  <= cfg_data[15:0];
				bca_pkg::REG_P_OSR:      p_osr_q     <= cfg_data[2:0];
				bca_pkg::REG_T_OSR:      t_osr_q     <= cfg_data[2:0];
				bca_pkg::REG_ALT_OFFSET: alt_off_q   <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// coefficient unpack
	logic signed [11:0] c0, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;

	assign c0  = {calib_lo_q[7:0], calib_lo_q[15:12]};
	assign c1  = {calib_lo_q[11:8], calib_lo_q[23:16]};
	assign c00 = {calib_lo_q[31:24], calib_lo_q[39:32], calib_lo_q[47:44]};
	assign c10 = {calib_lo_q[43:40], calib_lo_q[55:48], calib_lo_q[63:56]};
	assign c01 = {calib_mid_q[7:0], calib_mid_q[15:8]};
	assign c11 = {calib_mid_q[23:16], calib_mid_q[31:24]};
	assign c20 = {calib_mid_q[39:32], calib_mid_q[47:40]};
	assign c21 = {calib_mid_q[55:48], calib_mid_q[63:56]};
	assign c30 = {calib_hi_q[7:0], calib_hi_q[15:8]};

	// flow control: the whole pipe advances together
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// stages 1-4: scaled samples
	logic signed [SW-1:0] psc, tsc;

	bca_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_p (
		.clk  (clk),
		.en   (en),
		.raw  (raw_pressure),
		.code (p_osr_q),
		.sc   (psc)
	);

	bca_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_t (
		.clk  (clk),
		.en   (en),
		.raw  (raw_temperature),
		.code (t_osr_q),
		.sc   (tsc)
	);

	// stage 5: short products
	logic signed [SW+11:0] c1t;
	logic signed [SW+15:0] c30p, c21p, c01t;
	bca_pkg::word_t ttmp_s5, t1_s5, u_s5, ct_s5;

	assign c1t  = c1 * tsc;
	assign c30p = c30 * psc;
	assign c21p = c21 * psc;
	assign c01t = c01 * tsc;

	logic signed [23:0] temp_s6;
	bca_pkg::word_t t2_s9, pa_s13, p1_s14, p_s15, d_s16;
	logic signed [31:0] press_s16;

	// altitude front
	logic [IW-2:0]      dmag;
	logic [IW-2:0]      dround;
	logic [58:0]        x_s17;
	logic               dneg_s17;
	logic signed [IW+3:0] dext, d9;
	bca_pkg::word_t     h9_s17;
	bca_pkg::word_t     a3_s20, h_s30, h2_s31;
	logic signed [31:0] alt_s32;

	assign dmag   = d_s16[IW-1] ? (IW-1)'(-d_s16) : (IW-1)'(d_s16);
	assign dround = dmag + (IW-1)'(bca_pkg::DIV1000_HALF);
	assign dext   = (IW+4)'(d_s16);
	assign d9     = (dext <<< 3) + dext;

	always_ff @(posedge clk) begin
		if (en) begin
			ttmp_s5 <= (bca_pkg::word_t'(c0) <<< (FRAC_BITS - 1)) + bca_pkg::word_t'(c1t);
			t1_s5   <= (bca_pkg::word_t'(c20) <<< FRAC_BITS) + bca_pkg::word_t'(c30p);
			u_s5    <= (bca_pkg::word_t'(c11) <<< FRAC_BITS) + bca_pkg::word_t'(c21p);
			ct_s5   <= bca_pkg::word_t'(c01t);
			temp_s6 <= bca_pkg::sat24(bca_pkg::rnd_shift(ttmp_s5, FRAC_BITS - 8));
		end
	end

	// pressure polynomial
	logic signed [SW-1:0] psc_d5, psc_d9;
	bca_pkg::word_t v_l7, u_d7, w_l10, m2_l8, m3_l12, ct_d13, w_d14;

	bca_dly #(.W(SW), .N(1)) u_psc_d5 (.clk(clk), .en(en), .d(psc), .q(psc_d5));
	bca_dly #(.W(SW), .N(5)) u_psc_d9 (.clk(clk), .en(en), .d(psc), .q(psc_d9));
	bca_dly #(.W(IW), .N(2)) u_u_d7   (.clk(clk), .en(en), .d(u_s5), .q(u_d7));
	bca_dly #(.W(IW), .N(8)) u_ct_d13 (.clk(clk), .en(en), .d(ct_s5), .q(ct_d13));
	bca_dly #(.W(IW), .N(4)) u_w_d14  (.clk(clk), .en(en), .d(w_l10), .q(w_d14));

	bca_mulsh #(.WA(SW), .WB(SW), .SH(FRAC_BITS)) u_mul_tp (
		.clk(clk), .en(en), .a(tsc), .b(psc), .y(v_l7)
	);
	bca_mulsh #(.WA(IW), .WB(IW), .SH(FRAC_BITS)) u_mul_w (
		.clk(clk), .en(en), .a(v_l7), .b(u_d7), .y(w_l10)
	);
	bca_mulsh #(.WA(IW), .WB(SW), .SH(FRAC_BITS)) u_mul_m2 (
		.clk(clk), .en(en), .a(t1_s5), .b(psc_d5), .y(m2_l8)
	);
	bca_mulsh #(.WA(IW), .WB(SW), .SH(FRAC_BITS)) u_mul_m3 (
		.clk(clk), .en(en), .a(t2_s9), .b(psc_d9), .y(m3_l12)
	);

	// saturating sums stay in the model's order
	always_ff @(posedge clk) begin
		if (en) begin
			t2_s9     <= bca_pkg::sat_add(bca_pkg::word_t'(c10) <<< FRAC_BITS, m2_l8);
			pa_s13    <= bca_pkg::sat_add(bca_pkg::word_t'(c00) <<< FRAC_BITS, m3_l12);
			p1_s14    <= bca_pkg::sat_add(pa_s13, ct_d13);
			p_s15     <= bca_pkg::sat_add(p1_s14, w_d14);
			press_s16 <= bca_pkg::sat32(bca_pkg::rnd_shift(p_s15, FRAC_BITS - 4));
			d_s16     <= bca_pkg::sat_add(
				bca_pkg::word_t'(bca_pkg::SEA_LEVEL_PA) <<< FRAC_BITS, -p_s15);
			x_s17     <= dround[IW-2:3];
			dneg_s17  <= d_s16[IW-1];
			if (d9 > (IW+4)'(bca_pkg::LIM))
				h9_s17 <= bca_pkg::LIM;
			else if (d9 < -((IW+4)'(bca_pkg::LIM)))
				h9_s17 <= -bca_pkg::LIM;
			else
				h9_s17 <= d9[IW-1:0];
		end
	end

	// divide by 1000: round, drop three bits, then multiply by the reciprocal of 125
	logic signed [121:0] q125;
	logic                dneg_d19;
	logic [51:0]         a3mag;

	bca_mul #(.WA(60), .WB(62)) u_mul_div (
		.clk  (clk),
		.en   (en),
		.a    ($signed({1'b0, x_s17})),
		.b    ($signed({1'b0, bca_pkg::DIV125_RECIP[60:0]})),
		.prod (q125)
	);

	bca_dly #(.W(1), .N(2)) u_dneg_d19 (.clk(clk), .en(en), .d(dneg_s17), .q(dneg_d19));

	assign a3mag = q125[bca_pkg::DIV125_SH+51:bca_pkg::DIV125_SH];

	// cubic term
	bca_pkg::word_t sq_l23, a3_d23, cu_l26, h0_l29, h9_d29;

	bca_dly #(.W(IW), .N(3))  u_a3_d23 (.clk(clk), .en(en), .d(a3_s20), .q(a3_d23));
	bca_dly #(.W(IW), .N(12)) u_h9_d29 (.clk(clk), .en(en), .d(h9_s17), .q(h9_d29));

	bca_mulsh #(.WA(IW), .WB(IW), .SH(FRAC_BITS)) u_mul_sq (
		.clk(clk), .en(en), .a(a3_s20), .b(a3_s20), .y(sq_l23)
	);
	bca_mulsh #(.WA(IW), .WB(IW), .SH(FRAC_BITS)) u_mul_cu (
		.clk(clk), .en(en), .a(sq_l23), .b(a3_d23), .y(cu_l26)
	);
	bca_mulsh #(.WA(IW), .WB(31), .SH(bca_pkg::K082_SH)) u_mul_k (
		.clk(clk), .en(en), .a(cu_l26), .b(bca_pkg::K082_Q30), .y(h0_l29)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a3_s20  <= dneg_d19 ? -bca_pkg::word_t'(a3mag) : bca_pkg::word_t'(a3mag);
			h_s30   <= bca_pkg::sat_add(h0_l29, h9_d29);
			h2_s31  <= bca_pkg::sat_add(h_s30, -(bca_pkg::word_t'(alt_off_q) <<< FRAC_BITS));
			alt_s32 <= bca_pkg::sat32(bca_pkg::rnd_shift(h2_s31, FRAC_BITS));
		end
	end

	// align temperature and pressure with altitude
	logic [23:0] temp_d32;
	logic [31:0] press_d32;

	bca_dly #(.W(24), .N(26)) u_temp_d32  (.clk(clk), .en(en), .d(temp_s6), .q(temp_d32));
	bca_dly #(.W(32), .N(16)) u_press_d32 (.clk(clk), .en(en), .d(press_s16), .q(press_d32));

	assign temperature_q8 = temp_d32;
	assign pressure_q4    = press_d32;
	assign altitude_cm    = alt_s32;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted transaction missing from first stage");
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_q[LAT-2]))
		else $error("result appeared without a transaction behind it");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the barometer compensation and altitude pipeline.
module testbench;

	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [23:0] temp_q8;
		logic signed [31:0] press_q4;
		logic signed [31:0] alt_cm;
	} reading_t;

	class baro_scoreboard;
		logic [63:0] cal_lo, cal_mid;
		logic [15:0] cal_hi;
		logic [2:0] p_code, t_code;
		longint alt_off;
		reading_t pending[$];

		function new();
			cal_lo = '0; cal_mid = '0; cal_hi = '0;
			p_code = 3'd4; t_code = 3'd3; alt_off = 16300;
		endfunction

		function void set_reg(bca_pkg::reg_idx_t idx, logic [63:0] v);
			case (idx)
				bca_pkg::REG_CALIB_LOW:  cal_lo = v;
				bca_pkg::REG_CALIB_MID:  cal_mid = v;
				bca_pkg::REG_CALIB_HIGH: cal_hi = v[15:0];
				bca_pkg::REG_P_OSR:      p_code = v[2:0];
				bca_pkg::REG_T_OSR:      t_code = v[2:0];
				bca_pkg::REG_ALT_OFFSET: alt_off = longint'(signed'(v[20:0]));
				default: ;
			endcase
		endfunction

		function logic [7:0] cal_byte(int n);
			if (n < 8) return cal_lo[8*n +: 8];
			if (n < 16) return cal_mid[8*(n-8) +: 8];
			return cal_hi[8*(n-16) +: 8];
		endfunction

		function longint pair16(int n);
			logic signed [15:0] v;
			v = {cal_byte(n), cal_byte(n+1)};
			return longint'(v);
		endfunction

		function longint clampv(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint sadd(longint a, longint b);
			return clampv(a + b, -(64'sd1 <<< 61), 64'sd1 <<< 61);
		endfunction

		// round(a*b / 2^s) with ties away from zero, saturated
		function longint mul_round(longint a, longint b, int s);
			logic [63:0] ma, mb;
			logic [127:0] pr;
			bit neg;
			neg = (a < 0) != (b < 0);
			ma = a; mb = b;
			if (a < 0) ma = -ma;
			if (b < 0) mb = -mb;
			pr = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (s - 1))) >> s;
			if (pr > (128'd1 << 61)) pr = 128'd1 << 61;
			return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
		endfunction

		function longint scale_raw(logic signed [23:0] raw, logic [2:0] code);
			longint ktab[8] = '{524288, 1572864, 3670016, 7864320,
				253952, 516096, 1040384, 2088960};
			longint k, mag, q, top;
			k = ktab[code];
			mag = raw < 0 ? -longint'(raw) : longint'(raw);
			q = ((mag << 23) + k / 2) / k;
			top = 64'sd1 <<< 28;
			if (raw < 0) return q > top ? -top : -q;
			return q > top - 1 ? top - 1 : q;
		endfunction

		function void note(logic signed [23:0] rp, logic signed [23:0] rt);
			longint one, c0, c1, c00, c10, c01, c11, c20, c21, c30;
			longint psc, tsc, t, p, u, d, m, a3, h;
			logic signed [11:0] w12;
			logic signed [19:0] w20;
			logic [7:0] b1, b5;
			reading_t r;
			one = 64'sd1 <<< 23;
			b1 = cal_byte(1);
			b5 = cal_byte(5);
			w12 = {cal_byte(0), b1[7:4]}; c0 = w12;
			w12 = {b1[3:0], cal_byte(2)}; c1 = w12;
			w20 = {cal_byte(3), cal_byte(4), b5[7:4]}; c00 = w20;
			w20 = {b5[3:0], cal_byte(6), cal_byte(7)}; c10 = w20;
			c01 = pair16(8); c11 = pair16(10); c20 = pair16(12);
			c21 = pair16(14); c30 = pair16(16);
			psc = scale_raw(rp, p_code);
			tsc = scale_raw(rt, t_code);

			t = c0 * (one / 2) + c1 * tsc;
			r.temp_q8 = 24'(clampv(mul_round(t, 1, 15), -64'sd8388608, 64'sd8388607));

			t = c20 * one + c30 * psc;
			t = sadd(c10 * one, mul_round(t, psc, 23));
			p = sadd(c00 * one, mul_round(t, psc, 23));
			p = sadd(p, c01 * tsc);
			u = c11 * one + c21 * psc;
			p = sadd(p, mul_round(mul_round(tsc, psc, 23), u, 23));
			r.press_q4 = 32'(clampv(mul_round(p, 1, 19), -64'sd2147483648, 64'sd2147483647));

			d = sadd(101400 * one, -p);
			m = d < 0 ? -d : d;
			m = (m + 500) / 1000;
			a3 = d < 0 ? -m : m;
			h = mul_round(mul_round(mul_round(a3, a3, 23), a3, 23), 880468296, 30);
			h = sadd(h, mul_round(d, 64'sd9 <<< 23, 23));
			h = sadd(h, -(alt_off * one));
			r.alt_cm = 32'(clampv(mul_round(h, 1, 23), -64'sd2147483648, 64'sd2147483647));
			pending.push_back(r);
		endfunction

		// Empty string when the reading matches the oldest expectation
		function string check(reading_t got);
			reading_t w;
			string s;
			if (pending.size() == 0) return "reading with nothing expected";
			w = pending.pop_front();
			s = "";
			if (got.temp_q8 !== w.temp_q8)
				s = {s, $sformatf(" temperature_q8 %0d exp %0d", got.temp_q8, w.temp_q8)};
			if (got.press_q4 !== w.press_q4)
				s = {s, $sformatf(" pressure_q4 %0d exp %0d", got.press_q4, w.press_q4)};
			if (got.alt_cm !== w.alt_cm)
				s = {s, $sformatf(" altitude_cm %0d exp %0d", got.alt_cm, w.alt_cm)};
			return s;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] raw_pressure = '0;
	logic signed [23:0] raw_temperature = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] temperature_q8;
	logic signed [31:0] pressure_q4;
	logic signed [31:0] altitude_cm;
	logic cfg_wr = 1'b0;
	logic [bca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	baro_scoreboard sb = new();
	int errors = 0;
	int quiet = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;

	barometer_compensation_altitude dut (.*);

	always #4 clk = ~clk;

	task automatic report(string msg);
		$display("ERROR @%0t:%s", $realtime, msg);
		errors++;
	endtask

	// Check readings and note accepted samples; the watchdog shares this edge
	always @(posedge clk) begin
		reading_t got;
		string msg;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.temp_q8 = temperature_q8;
				got.press_q4 = pressure_q4;
				got.alt_cm = altitude_cm;
				msg = sb.check(got);
				if (msg != "") report(msg);
			end
			if (in_valid && in_ready) sb.note(raw_pressure, raw_temperature);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL barometer_compensation_altitude");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off when requested
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic write_reg(bca_pkg::reg_idx_t idx, logic [63:0] v);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic setup(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
			logic [63:0] pc, logic [63:0] tc, logic [63:0] off);
		write_reg(bca_pkg::REG_CALIB_LOW, lo);
		write_reg(bca_pkg::REG_CALIB_MID, mid);
		write_reg(bca_pkg::REG_CALIB_HIGH, hi);
		write_reg(bca_pkg::REG_P_OSR, pc);
		write_reg(bca_pkg::REG_T_OSR, tc);
		write_reg(bca_pkg::REG_ALT_OFFSET, off);
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic send(logic signed [23:0] p, logic signed [23:0] t);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= p;
		raw_temperature <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait for every reading, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic directed_set();
		send(24'sd0, 24'sd0);
		send(24'sh7FFFFF, 24'sh7FFFFF);
		send(24'sh800000, 24'sh800000);
		send(24'sh7FFFFF, 24'sh800000);
		send(24'sh800000, 24'sh7FFFFF);
		send(-24'sd1, 24'sd1);
		send(24'sd1, -24'sd1);
		drain();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [23:0] rand_raw();
		case ($urandom_range(9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(8191)) - 24'sd4096;
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults, then all-ones calibration with the lowest codes,
		// then mixed-sign calibration with the highest codes
		directed_set();
		setup('1, '1, 64'hFFFF, 64'd0, 64'd0, 64'h1F_0010_0000);
		directed_set();
		setup(64'h807F_F800_0008_7F80, 64'h8000_7FFF_0001_FFFF, 64'h7FFF, 64'd7, 64'd7,
			64'h0F_FFFF);
		directed_set();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 10; rx_idle_pct = 86;
			end else if (ph < 6) begin
				tx_idle_pct = 86; rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			setup(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
			if (ph == 6) rx_hold = 300;
			for (int i = 0; i < 120; i++) send(rand_raw(), rand_raw());
			drain();
		end

		if (errors == 0)
			$display("PASS barometer_compensation_altitude");
		else
			$display("FAIL barometer_compensation_altitude");
		$finish;
	end
endmodule
